FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequent that must hold whenever the antecedent holds at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mfb_pkg.sv
package mfb_pkg;

    // Number of header words sent ahead of the payload.
    localparam int unsigned HEADER_WORDS = 6;
    // Longest burst of words that one item can cause: the header and the trailer.
    localparam int unsigned MAX_WORDS    = HEADER_WORDS + 1;
    localparam int unsigned COUNT_W      = $clog2(MAX_WORDS + 1);

    localparam logic [7:0] PREAMBLE_BYTE  = 8'h55;
    localparam logic [7:0] NO_CRC_TRAILER = 8'hAA;
    localparam logic [7:0] CRC_GENERATOR  = 8'h07;
    localparam logic [7:0] SOURCE_RESET   = 8'h16;
    localparam logic [7:0] DEST_RESET     = 8'h01;
    localparam logic [7:0] VERSION_RESET  = 8'h01;

    localparam logic [1:0] PAIR_ONE  = 2'b01;
    localparam logic [1:0] PAIR_ZERO = 2'b10;

    // Request codes.
    localparam logic [1:0] REQ_START     = 2'd0;
    localparam logic [1:0] REQ_PAYLOAD   = 2'd1;
    localparam logic [1:0] REQ_COLLISION = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ABORT      = 2'd1;
    localparam logic [1:0] ST_UNEXPECTED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SOURCE  = 2'd0;
    localparam logic [1:0] REG_DEST    = 2'd1;
    localparam logic [1:0] REG_VERSION = 2'd2;
    localparam logic [1:0] REG_CRC_EN  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [15:0] code_word;
        logic        frame_end;
        logic [1:0]  status;
    } out_t;

    // Manchester code: a one becomes 01, a zero becomes 10, bit 7 in the top pair.
    function automatic logic [15:0] manchester(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            w[2*i +: 2] = b[i] ? PAIR_ONE : PAIR_ZERO;
        end
        return w;
    endfunction

    // One byte through CRC-8, polynomial 0x07, MSB first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_GENERATOR) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/manchester_frame_builder_crc8.sv
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_ready   mfb_pkg::in_t  (req_type, payload_length, data_byte)
// out       output     out_valid / out_ready mfb_pkg::out_t (code_word, frame_end, status)
// cfg       input      cfg_write             cfg_index, cfg_data (write only)
//
// A start item produces six header words, seven when the payload is empty; a payload item
// produces one word, two for the last byte of a frame; any other item one status word.
// Words leave the output register at one per cycle while the output is not stalled, so an
// item holds the input until its last word moves out, which is when the next item is accepted.
// Reset is asynchronous and active low; it clears the frame state and loads the defaults.
// An output stall holds the output word, the queued words and, while any are queued, the input.
module manchester_frame_builder_crc8 (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mfb_pkg::in_t  in_word,
    output logic          out_valid,
    input  logic          out_ready,
    output mfb_pkg::out_t out_word,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data
);

    // Configuration registers.
    logic [7:0] source_reg;
    logic [7:0] dest_reg;
    logic [7:0] version_reg;
    logic       crc_en_reg;

    // Frame state, updated in the cycle an item is accepted.
    logic       active_reg,    active_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] crc_reg,       crc_next;

    // Word queue of the item in progress. The bytes shift toward entry zero as words
    // leave; count_reg tells how many words are still to go.
    logic [7:0]                   job_byte_reg  [mfb_pkg::MAX_WORDS];
    logic [7:0]                   job_byte_next [mfb_pkg::MAX_WORDS];
    logic [mfb_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                         end_reg, end_next;
    logic [1:0]                   status_reg, status_next;

    // Output register.
    logic          out_valid_reg;
    mfb_pkg::out_t out_reg;

    logic       accept;
    logic       out_load;
    logic       advance;
    logic [7:0] crc_calc;
    logic [7:0] rem_dec;
    logic       last_word;

    assign out_load  = !out_valid_reg || out_ready;
    assign advance   = (count_reg != '0) && out_load;
    assign last_word = (count_reg == mfb_pkg::COUNT_W'(1));
    // The input is free when the queue is empty or its last word moves out now.
    assign in_ready  = (count_reg == '0) || (last_word && out_load);
    assign accept    = in_valid && in_ready;

    assign crc_calc = mfb_pkg::crc8_update(crc_reg, in_word.data_byte);
    assign rem_dec  = remaining_reg - 8'd1;

    // Decode the incoming item into its queue of words and its effect on the frame.
    always_comb
    begin
        active_next    = active_reg;
        remaining_next = remaining_reg;
        crc_next       = crc_reg;
        for (int i = 0; i < mfb_pkg::MAX_WORDS; i++)
        begin
            job_byte_next[i] = '0;
        end
        count_next  = mfb_pkg::COUNT_W'(1);
        end_next    = 1'b0;
        status_next = mfb_pkg::ST_UNEXPECTED;

        unique case (in_word.req_type)
            mfb_pkg::REQ_START:
            begin
                // A new start silently drops any frame that is still open.
                job_byte_next[0] = mfb_pkg::PREAMBLE_BYTE;
                job_byte_next[1] = version_reg;
                job_byte_next[2] = source_reg;
                job_byte_next[3] = dest_reg;
                job_byte_next[4] = in_word.payload_length;
                job_byte_next[5] = {7'd0, crc_en_reg};
                // The CRC over an empty payload is zero.
                job_byte_next[6] = crc_en_reg ? 8'h00 : mfb_pkg::NO_CRC_TRAILER;
                status_next      = mfb_pkg::ST_OK;
                crc_next         = '0;
                remaining_next   = in_word.payload_length;
                if (in_word.payload_length == '0)
                begin
                    count_next  = mfb_pkg::COUNT_W'(mfb_pkg::MAX_WORDS);
                    end_next    = 1'b1;
                    active_next = 1'b0;
                end
                else
                begin
                    count_next  = mfb_pkg::COUNT_W'(mfb_pkg::HEADER_WORDS);
                    active_next = 1'b1;
                end
            end
            mfb_pkg::REQ_PAYLOAD:
            begin
                if (active_reg)
                begin
                    job_byte_next[0] = in_word.data_byte;
                    job_byte_next[1] = crc_en_reg ? crc_calc : mfb_pkg::NO_CRC_TRAILER;
                    status_next      = mfb_pkg::ST_OK;
                    crc_next         = crc_calc;
                    remaining_next   = rem_dec;
                    if (rem_dec == '0)
                    begin
                        count_next  = mfb_pkg::COUNT_W'(2);
                        end_next    = 1'b1;
                        active_next = 1'b0;
                    end
                end
            end
            mfb_pkg::REQ_COLLISION:
            begin
                // A collision only aborts an open frame; otherwise it is unexpected.
                if (active_reg)
                begin
                    status_next    = mfb_pkg::ST_ABORT;
                    active_next    = 1'b0;
                    remaining_next = '0;
                    crc_next       = '0;
                end
            end
            default:
            begin
                status_next = mfb_pkg::ST_UNEXPECTED;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg  <= mfb_pkg::SOURCE_RESET;
            dest_reg    <= mfb_pkg::DEST_RESET;
            version_reg <= mfb_pkg::VERSION_RESET;
            crc_en_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mfb_pkg::REG_SOURCE:  source_reg  <= cfg_data;
                mfb_pkg::REG_DEST:    dest_reg    <= cfg_data;
                mfb_pkg::REG_VERSION: version_reg <= cfg_data;
                mfb_pkg::REG_CRC_EN:  crc_en_reg  <= cfg_data[0];
                default:              source_reg  <= source_reg;
            endcase
        end
    end

    // Frame state and queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            remaining_reg <= '0;
            crc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                active_reg    <= active_next;
                remaining_reg <= remaining_next;
                crc_reg       <= crc_next;
                count_reg     <= count_next;
            end
            else if (advance)
            begin
                count_reg <= count_reg - mfb_pkg::COUNT_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= (count_reg != '0);
            end
        end
    end

    // Queue bytes and the output word carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < mfb_pkg::MAX_WORDS; i++)
            begin
                job_byte_reg[i] <= job_byte_next[i];
            end
            end_reg    <= end_next;
            status_reg <= status_next;
        end
        else if (advance)
        begin
            for (int i = 0; i < mfb_pkg::MAX_WORDS - 1; i++)
            begin
                job_byte_reg[i] <= job_byte_reg[i+1];
            end
            job_byte_reg[mfb_pkg::MAX_WORDS-1] <= '0;
        end

        if (advance)
        begin
            // Status words carry no code; only the frame's last word carries the end mark.
            out_reg.code_word <= (status_reg == mfb_pkg::ST_OK)
                                 ? mfb_pkg::manchester(job_byte_reg[0]) : 16'h0000;
            out_reg.frame_end <= end_reg && last_word;
            out_reg.status    <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: hw/rtl/mfb_checker.sv
`include "assert_macros.svh"

module mfb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input mfb_pkg::out_t out_word
);

    logic in_fire;
    logic out_stall;
    logic out_status_word;
    logic out_frame_end;
    logic status_clean;
    logic end_good;

    assign in_fire         = in_valid && in_ready;
    assign out_stall       = out_valid && !out_ready;
    assign out_status_word = out_valid && (out_word.status != mfb_pkg::ST_OK);
    assign out_frame_end   = out_valid && out_word.frame_end;
    assign status_clean    = (out_word.code_word == 16'h0000) && !out_word.frame_end;
    assign end_good        = (out_word.status == mfb_pkg::ST_OK);

    // A stalled output word stays put.
    `ASSERT_IMPLIES(a_out_hold, out_stall, ##1 (out_valid && $stable(out_word)), "stall broken")

    // Abort and unexpected-item words carry an empty code and never end a frame.
    `ASSERT_IMPLIES(a_status_empty, out_status_word, status_clean, "status word carries data")

    // The trailer is always a good word.
    `ASSERT_IMPLIES(a_end_ok, out_frame_end, end_good, "frame end on a status word")

    // Every accepted item shows a word at the output.
    `ASSERT_IMPLIES(a_item_output, in_fire, ##2 out_valid, "accepted item produced no word")

endmodule

bind manchester_frame_builder_crc8 mfb_checker u_mfb_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    // Request type 3 has no meaning; the block answers it with an unexpected-item status.
    localparam logic [1:0] REQ_UNDEFINED = 2'd3;

    // Cycles without any word moving on either channel before the run is declared hung.
    // The longest quiet stretch of a correct run is a drawn wait on either side, or the
    // register writes and settling between phases; this leaves a wide margin.
    localparam int unsigned QUIET_LIMIT = 1000;

    // Cycles allowed after the last expected word before the final verdict.
    localparam int unsigned SETTLE_CYCLES = 20;

    // Random words per configuration phase.
    localparam int unsigned PHASE_WORDS = 62;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    mfb_pkg::in_t  in_word = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    mfb_pkg::out_t out_word;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = mfb_pkg::REG_SOURCE;
    logic [7:0] cfg_data = 8'h00;

    // Input words waiting to be driven, and code words the block still owes us.
    mfb_pkg::in_t  pending[$];
    mfb_pkg::out_t words_due[$];

    // Our copy of the configuration registers, kept in step with every write.
    logic [7:0] cf_source = mfb_pkg::SOURCE_RESET;
    logic [7:0] cf_dest = mfb_pkg::DEST_RESET;
    logic [7:0] cf_version = mfb_pkg::VERSION_RESET;
    logic       cf_crc_en = 1'b1;

    // Frame state as the block should see it after every accepted word.
    logic       open_frame = 1'b0;
    logic [7:0] bytes_left = 8'h00;
    logic [7:0] crc_acc = 8'h00;

    // Frame state of the stimulus generator, so that random frames stay well formed
    // across configuration phases.
    int unsigned plan_left = 0;

    // Upper bounds for the per-word waits on each side; zero gives back-to-back traffic.
    int unsigned in_gap_max = 16;
    int unsigned out_gap_max = 16;

    int unsigned in_wait = 0;
    int unsigned out_hold = 0;
    int unsigned quiet_cycles = 0;
    int unsigned errors = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    manchester_frame_builder_crc8 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Line code of one byte, built from the top bit down: a one is sent as 01 and a
    // zero as 10, so bit 7 ends up in the two top bits of the word.
    function automatic logic [15:0] line_code(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int i = 7; i >= 0; i--)
        begin
            w = {w[13:0], (b[i] ? 2'b01 : 2'b10)};
        end
        return w;
    endfunction

    // CRC-8 with polynomial 0x07, one message bit at a time, most significant bit first.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       feedback;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = c[7] ^ b[i];
            c = {c[6:0], 1'b0};
            if (feedback)
            begin
                c = c ^ mfb_pkg::CRC_GENERATOR;
            end
        end
        return c;
    endfunction

    function automatic mfb_pkg::in_t make_word(input logic [1:0] req, input logic [7:0] len,
                                               input logic [7:0] data);
        mfb_pkg::in_t w;
        w.req_type = req;
        w.payload_length = len;
        w.data_byte = data;
        return w;
    endfunction

    task automatic owe_word(input logic [15:0] code, input logic last, input logic [1:0] st);
        mfb_pkg::out_t w;
        w.code_word = code;
        w.frame_end = last;
        w.status = st;
        words_due.push_back(w);
    endtask

    // The trailer carries the CRC when it is enabled as the last input word is taken,
    // and a fixed pattern otherwise.
    task automatic owe_trailer();
        owe_word(line_code(cf_crc_en ? crc_acc : mfb_pkg::NO_CRC_TRAILER), 1'b1,
                 mfb_pkg::ST_OK);
        open_frame = 1'b0;
    endtask

    // Works out every code word that one accepted input word causes, in order.
    task automatic frame_step(input mfb_pkg::in_t w);
        case (w.req_type)
            mfb_pkg::REQ_START:
            begin
                // A start while a frame is open silently drops the old frame.
                owe_word(line_code(mfb_pkg::PREAMBLE_BYTE), 1'b0, mfb_pkg::ST_OK);
                owe_word(line_code(cf_version), 1'b0, mfb_pkg::ST_OK);
                owe_word(line_code(cf_source), 1'b0, mfb_pkg::ST_OK);
                owe_word(line_code(cf_dest), 1'b0, mfb_pkg::ST_OK);
                owe_word(line_code(w.payload_length), 1'b0, mfb_pkg::ST_OK);
                owe_word(line_code({7'd0, cf_crc_en}), 1'b0, mfb_pkg::ST_OK);
                crc_acc = 8'h00;
                bytes_left = w.payload_length;
                open_frame = 1'b1;
                // An empty payload closes the frame right after the header.
                if (w.payload_length == 8'd0)
                begin
                    owe_trailer();
                end
            end
            mfb_pkg::REQ_PAYLOAD:
            begin
                if (!open_frame)
                begin
                    owe_word(16'h0000, 1'b0, mfb_pkg::ST_UNEXPECTED);
                end
                else
                begin
                    crc_acc = crc_byte(crc_acc, w.data_byte);
                    owe_word(line_code(w.data_byte), 1'b0, mfb_pkg::ST_OK);
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                    begin
                        owe_trailer();
                    end
                end
            end
            mfb_pkg::REQ_COLLISION:
            begin
                // A collision only aborts a frame that is open; otherwise it is unexpected.
                if (open_frame)
                begin
                    open_frame = 1'b0;
                    bytes_left = 8'h00;
                    crc_acc = 8'h00;
                    owe_word(16'h0000, 1'b0, mfb_pkg::ST_ABORT);
                end
                else
                begin
                    owe_word(16'h0000, 1'b0, mfb_pkg::ST_UNEXPECTED);
                end
            end
            default:
            begin
                owe_word(16'h0000, 1'b0, mfb_pkg::ST_UNEXPECTED);
            end
        endcase
    endtask

    // Register writes only happen while nothing is in flight, so our copy can follow
    // the write at once.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mfb_pkg::REG_SOURCE:  cf_source = val;
            mfb_pkg::REG_DEST:    cf_dest = val;
            mfb_pkg::REG_VERSION: cf_version = val;
            mfb_pkg::REG_CRC_EN:  cf_crc_en = val[0];
        endcase
    endtask

    // Waits until every queued word has been accepted and every owed word has arrived,
    // then idles before returning. Checks are made at the falling edge so that
    // they see the settled results of the rising edge.
    task automatic wait_until_drained();
        @(negedge clk);
        while (pending.size() != 0 || in_valid || words_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic plan_start();
        mfb_pkg::in_t w;
        int unsigned  pick;
        w = make_word(mfb_pkg::REQ_START, 8'h00, 8'($urandom_range(255, 0)));
        // Short frames keep the run fast; now and then a long one, up to the maximum.
        pick = $urandom_range(99, 0);
        if (pick < 80)
        begin
            w.payload_length = 8'($urandom_range(6, 0));
        end
        else if (pick < 95)
        begin
            w.payload_length = 8'($urandom_range(24, 7));
        end
        else
        begin
            w.payload_length = 8'($urandom_range(255, 25));
        end
        plan_left = 32'(w.payload_length);
        pending.push_back(w);
    endtask

    // Mostly complete frames with random content; the rest is collisions, restarts,
    // stray bytes and undefined requests. Unread fields are random as well.
    task automatic plan_traffic(input int unsigned count);
        mfb_pkg::in_t w;
        int unsigned  pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            w = make_word(mfb_pkg::REQ_PAYLOAD, 8'($urandom_range(255, 0)),
                          8'($urandom_range(255, 0)));
            pick = $urandom_range(99, 0);
            if (plan_left != 0)
            begin
                if (pick < 4)
                begin
                    w.req_type = mfb_pkg::REQ_COLLISION;
                    plan_left = 0;
                    pending.push_back(w);
                end
                else if (pick < 7)
                begin
                    plan_start();
                end
                else
                begin
                    if (pick < 9)
                    begin
                        w.req_type = REQ_UNDEFINED;
                    end
                    else
                    begin
                        plan_left--;
                    end
                    pending.push_back(w);
                end
            end
            else if (pick < 70)
            begin
                plan_start();
            end
            else
            begin
                if (pick >= 90)
                begin
                    w.req_type = REQ_UNDEFINED;
                end
                else if (pick >= 80)
                begin
                    w.req_type = mfb_pkg::REQ_COLLISION;
                end
                pending.push_back(w);
            end
        end
    endtask

    // Driver: presents the next pending word after its drawn wait, holds it steady until
    // the block takes it, and predicts the block's answer at the moment of acceptance.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                frame_step(in_word);
            end
            if (!in_valid || in_ready)
            begin
                if (in_wait != 0)
                begin
                    in_valid <= 1'b0;
                    in_wait <= in_wait - 1;
                end
                else if (pending.size() != 0)
                begin
                    in_word <= pending.pop_front();
                    in_valid <= 1'b1;
                    in_wait <= $urandom_range(in_gap_max, 0);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted code word against the oldest owed word, then draws
    // how long to hold off before taking the next one.
    always @(posedge clk)
    begin : monitor
        mfb_pkg::out_t owed;
        int unsigned   stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_hold <= 0;
        end
        else
        begin
            stall = out_hold;
            if (out_valid && out_ready)
            begin
                stall = $urandom_range(out_gap_max, 0);
                if (words_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: word %h arrived with none expected", $time, out_word);
                end
                else
                begin
                    owed = words_due.pop_front();
                    if (out_word.code_word !== owed.code_word)
                    begin
                        errors++;
                        $display("%0t: code_word expected %h, got %h",
                                 $time, owed.code_word, out_word.code_word);
                    end
                    if (out_word.frame_end !== owed.frame_end)
                    begin
                        errors++;
                        $display("%0t: frame_end expected %b, got %b",
                                 $time, owed.frame_end, out_word.frame_end);
                    end
                    if (out_word.status !== owed.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, owed.status, out_word.status);
                    end
                end
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                out_hold <= stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                out_hold <= 0;
            end
        end
    end

    // Watchdog: a run where no word moves on either side for too long has hung.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [7:0] src;
        logic [7:0] dst;
        logic [7:0] ver;
        logic       crc_on;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames with the reset configuration. An empty frame first: header and
        // trailer at once.
        pending.push_back(make_word(mfb_pkg::REQ_START, 8'd0, 8'hFF));
        // Stray payload byte, collision with no frame open, and an undefined request.
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'hFF, 8'hFF));
        pending.push_back(make_word(mfb_pkg::REQ_COLLISION, 8'h00, 8'h00));
        pending.push_back(make_word(REQ_UNDEFINED, 8'hFF, 8'hFF));
        // One-byte and two-byte frames with the extreme byte values.
        pending.push_back(make_word(mfb_pkg::REQ_START, 8'd1, 8'hFF));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'h00));
        pending.push_back(make_word(mfb_pkg::REQ_START, 8'd2, 8'h00));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'hFF));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'hFF, 8'hA5));
        // Longest frame, dropped by a restart, then the new frame aborted by a collision.
        pending.push_back(make_word(mfb_pkg::REQ_START, 8'd255, 8'h00));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'h80));
        pending.push_back(make_word(mfb_pkg::REQ_START, 8'd3, 8'h5A));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'h01));
        pending.push_back(make_word(mfb_pkg::REQ_COLLISION, 8'hFF, 8'hFF));
        // A byte right after the abort is stray.
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h12, 8'h34));
        // Undefined request inside an open frame leaves the frame untouched.
        pending.push_back(make_word(mfb_pkg::REQ_START, 8'd3, 8'h00));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'h7F));
        pending.push_back(make_word(REQ_UNDEFINED, 8'h00, 8'h00));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'hFE));
        pending.push_back(make_word(mfb_pkg::REQ_PAYLOAD, 8'h00, 8'hC3));
        wait_until_drained();

        // Random phases, each under its own configuration and its own idling pattern.
        // A phase may end with a frame open, so a change of the CRC enable also lands in
        // the middle of a frame: its header keeps the old flag, its trailer uses the new.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src = 8'h00;
                    dst = 8'hFF;
                    ver = 8'h00;
                    crc_on = 1'b0;
                end
                1:
                begin
                    src = 8'hFF;
                    dst = 8'h00;
                    ver = 8'hFF;
                    crc_on = 1'b1;
                end
                default:
                begin
                    src = 8'($urandom_range(255, 0));
                    dst = 8'($urandom_range(255, 0));
                    ver = 8'($urandom_range(255, 0));
                    crc_on = 1'($urandom_range(1, 0));
                end
            endcase
            write_reg(mfb_pkg::REG_SOURCE, src);
            write_reg(mfb_pkg::REG_DEST, dst);
            write_reg(mfb_pkg::REG_VERSION, ver);
            write_reg(mfb_pkg::REG_CRC_EN, {7'd0, crc_on});
            @(negedge clk);
            in_gap_max = (ph == 1 || ph == 3) ? 0 : 16;
            out_gap_max = (ph == 2 || ph == 3) ? 0 : 16;
            plan_traffic(PHASE_WORDS);
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (words_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, words_due.size());
        end
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mfb_pkg.sv
hw/rtl/manchester_frame_builder_crc8.sv
hw/rtl/mfb_checker.sv
dv/tb.sv
